### rtl/steq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Shared sizes, codes and the per-entry record of the event queue.
// ----------------------------------------------------------------------------
package steq_pkg;

    localparam int QueueDepth = 16;
    localparam int OwnerCount = 16;
    localparam int IdxW       = $clog2(QueueDepth);
    localparam int CntW       = $clog2(QueueDepth + 1);

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_DISABLE = 3'd3,
        CMD_RELEASE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_TIMEOUT = 2'd0,
        KIND_DELETED = 2'd1,
        KIND_DROPPED = 2'd2
    } t_kind;

    // One queued event.
    typedef struct packed {
        logic signed [63:0] time_v;
        logic [3:0]         owner;
        logic [7:0]         callback;
        logic [31:0]        cookie;
    } t_entry;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        insert;   // shift right at and after pos
        logic        remove;   // shift left at and after pos
        logic [IdxW-1:0] pos;
        t_entry      new_entry;
    } t_cell_ctl;

endpackage

### rtl/sorted_timer_event_queue.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Time-ordered event queue held in a chain of cells with a walking sequencer.
// ----------------------------------------------------------------------------
// An add scans past each earlier entry, one step per entry, then inserts;
// an add to a full queue is dropped and reported as a dropped result.
// A tick or release steps over each entry in turn and removes each match as a
// result; the walk then closes and the module returns to idle.
// Only one request is taken at a time; a new one waits until the walk over the
// cells and any result stalls are over. Reset (synchronous, active low)
// empties the queue and clears every owner; entry contents are not cleared.
module sorted_timer_event_queue
    import steq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [3:0]  i_owner,
    input  logic signed [63:0] i_trigger_time,
    input  logic signed [63:0] i_current_time,
    input  logic [7:0]  i_callback_id,
    input  logic [31:0] i_cookie,
    input  logic [31:0] i_listener,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_owner_res,
    output logic [7:0]  o_callback_id_res,
    output logic [31:0] o_cookie_res,
    output logic [31:0] o_listener_out,
    output logic        o_last
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_WAIT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CntW-1:0]  r_count, n_count;
    logic [CntW-1:0]  r_pos, n_pos;
    logic [2:0]       r_cmd;
    logic [3:0]       r_owner;
    logic signed [63:0] r_time;
    logic [7:0]       r_cb;
    logic [31:0]      r_ck;
    logic [OwnerCount-1:0] r_active, n_active;
    logic [31:0]      r_listener [OwnerCount];
    logic             r_out_valid, n_out_valid;
    logic             r_out_show, n_out_show;
    logic [1:0]       r_kind, n_kind;
    logic [3:0]       r_o_owner, n_o_owner;
    logic [7:0]       r_o_cb, n_o_cb;
    logic [31:0]      r_o_ck, n_o_ck;
    logic [31:0]      r_o_lis, n_o_lis;
    logic             r_o_last, n_o_last;

    t_cell_ctl        w_ctl;
    t_entry           w_cells [QueueDepth];
    t_entry           w_head;
    logic             w_accept;
    logic             w_out_take;
    logic             w_out_free;
    logic             w_in_range;
    logic             w_owner_ok;
    logic             w_match;

    assign w_accept   = i_valid && o_ready;
    assign o_valid    = r_out_valid && r_out_show;
    assign w_out_take = o_valid && i_ready;
    assign w_out_free = !r_out_valid || w_out_take;
    assign o_ready    = (r_state == ST_IDLE);
    assign w_in_range = (r_pos < r_count);
    assign w_owner_ok = ({1'b0, i_owner} < 5'(OwnerCount));
    assign w_head     = w_cells[r_pos[IdxW-1:0]];

    // Chain of cells; the ends see a blank neighbour.
    for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
        t_entry w_l, w_r;
        if (g == 0) begin : g_first
            assign w_l = '0;
        end else begin : g_mid_l
            assign w_l = w_cells[g-1];
        end
        if (g == QueueDepth - 1) begin : g_last
            assign w_r = '0;
        end else begin : g_mid_r
            assign w_r = w_cells[g+1];
        end
        steq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IdxW'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_l),
            .i_right (w_r),
            .o_entry (w_cells[g])
        );
    end

    // Per-entry match for the current scan command.
    always_comb begin
        w_match = 1'b0;
        if (r_cmd == CMD_TICK) begin
            w_match = (w_head.time_v <= r_time) && r_active[w_head.owner];
        end else if (r_cmd == CMD_RELEASE) begin
            w_match = (w_head.owner == r_owner);
        end
    end

    // Sequencer: one scan or result step per cycle while the output is free.
    // A walk result is held from the receiver until it is known if more follow.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_active    = r_active;
        n_out_valid = r_out_valid && !w_out_take;
        n_out_show  = r_out_show;
        n_kind      = r_kind;
        n_o_owner   = r_o_owner;
        n_o_cb      = r_o_cb;
        n_o_ck      = r_o_ck;
        n_o_lis     = r_o_lis;
        n_o_last    = r_o_last;
        w_ctl       = '0;
        w_ctl.new_entry = '{time_v: r_time, owner: r_owner, callback: r_cb,
                            cookie: r_ck};
        w_ctl.pos   = r_pos[IdxW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pos = '0;
                    if (w_owner_ok) begin
                        priority case (i_command)
                            CMD_ADD, CMD_TICK, CMD_RELEASE: n_state = ST_SCAN;
                            CMD_ENABLE:  n_active[i_owner] = 1'b1;
                            CMD_DISABLE: n_active[i_owner] = 1'b0;
                            default: ;
                        endcase
                    end
                end
            end
            ST_SCAN: begin
                if (r_cmd == CMD_ADD) begin
                    if (r_count >= CntW'(QueueDepth)) begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_show  = 1'b1;
                            n_kind      = KIND_DROPPED;
                            n_o_owner   = r_owner;
                            n_o_cb      = r_cb;
                            n_o_ck      = r_ck;
                            n_o_lis     = '0;
                            n_o_last    = 1'b1;
                            n_state     = ST_IDLE;
                        end
                    end else if (w_in_range && w_head.time_v <= r_time) begin
                        n_pos = r_pos + 1'b1;
                    end else begin
                        w_ctl.insert = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else if (!w_in_range ||
                             (r_cmd == CMD_TICK && w_head.time_v > r_time)) begin
                    // Walk finished.
                    if (r_cmd == CMD_RELEASE) begin
                        n_active[r_owner] = 1'b0;
                    end
                    n_state = ST_WAIT;
                end else if (w_match) begin
                    n_state = ST_EMIT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            ST_EMIT: begin
                if (r_out_valid && !r_out_show) begin
                    // Another result follows, so the held one is not the final one.
                    n_out_show = 1'b1;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_show   = 1'b0;
                    n_kind       = (r_cmd == CMD_TICK) ? KIND_TIMEOUT : KIND_DELETED;
                    n_o_owner    = w_head.owner;
                    n_o_cb       = w_head.callback;
                    n_o_ck       = w_head.cookie;
                    n_o_lis      = (r_cmd == CMD_TICK) ? r_listener[w_head.owner] : '0;
                    n_o_last     = 1'b0;
                    w_ctl.remove = 1'b1;
                    n_count      = r_count - 1'b1;
                    n_state      = ST_SCAN;
                end
            end
            ST_WAIT: begin
                // Release the held result of the walk as the final one.
                if (r_out_valid && !r_out_show) begin
                    n_o_last   = 1'b1;
                    n_out_show = 1'b1;
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_out_show  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_out_show  <= n_out_show;
        end
    end

    // Listener table; cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OwnerCount; k++) begin
                r_listener[k] <= '0;
            end
        end else if (w_accept && w_owner_ok) begin
            if (i_command == CMD_ENABLE) begin
                r_listener[i_owner] <= i_listener;
            end else if (i_command == CMD_DISABLE || i_command == CMD_RELEASE) begin
                r_listener[i_owner] <= '0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_owner <= i_owner;
            r_time  <= (i_command == CMD_TICK) ? i_current_time : i_trigger_time;
            r_cb    <= i_callback_id;
            r_ck    <= i_cookie;
        end
        r_kind    <= n_kind;
        r_o_owner <= n_o_owner;
        r_o_cb    <= n_o_cb;
        r_o_ck    <= n_o_ck;
        r_o_lis   <= n_o_lis;
        r_o_last  <= n_o_last;
    end

    assign o_kind            = r_kind;
    assign o_owner_res       = r_o_owner;
    assign o_callback_id_res = r_o_cb;
    assign o_cookie_res      = r_o_ck;
    assign o_listener_out    = r_o_lis;
    assign o_last            = r_o_last;

    // The queue never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QueueDepth))
        else $error("entry count beyond queue depth");

    // A new request is taken only in the idle state.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> r_state == ST_IDLE)
        else $error("request accepted while busy");

    // A removal always shrinks the count by one.
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.remove |=> r_count == $past(r_count) - 1'b1)
        else $error("removal did not shrink the queue");

endmodule

### rtl/steq_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry, loads a new one at the insert position, and takes a value
// from its left or right neighbour when the queue opens a gap or closes one.
// ----------------------------------------------------------------------------
module steq_cell
    import steq_pkg::*;
(
    input  logic            i_clk,
    input  logic [IdxW-1:0] i_index,
    input  t_cell_ctl       i_ctl,
    input  t_entry          i_left,
    input  t_entry          i_right,
    output t_entry          o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // Select the next value for this cell.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (i_index == i_ctl.pos) begin
                n_entry = i_ctl.new_entry;
            end else if (i_index > i_ctl.pos) begin
                n_entry = i_left;
            end
        end else if (i_ctl.remove && i_index >= i_ctl.pos) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
